@@ sv/modexp_pkg.sv @@
// Shared state codes for the modular exponentiation block.
`default_nettype none
package modexp_pkg;

	typedef logic [2:0] state_t;

	localparam state_t ST_IDLE = 3'd0;
	localparam state_t ST_RED  = 3'd1;
	localparam state_t ST_CHK  = 3'd2;
	localparam state_t ST_MUL  = 3'd3;
	localparam state_t ST_DONE = 3'd4;

endpackage
`default_nettype wire

@@ sv/modular_exponentiation.sv @@
// Modular exponentiation by right-to-left square-and-multiply, bit-serial datapath.
//
// Usage:
//   Input channel (in_valid/in_ready, base, exponent) takes one item at a time.
//   Output channel (out_valid/out_ready, power) returns base^exponent mod modulus.
//   Config channel (cfg_valid/cfg_ready, modulus) writes the modulus; send it
//   only while no item is in flight. It is always ready.
// Sequence: the item is loaded, the base is reduced one bit at a time, then
//   for each exponent bit one check step, a multiply into the product when
//   the bit is set, and the square of the base; then a final check and the
//   write of the output register. A modulus below 2 answers 0 and skips the
//   reduction and the multiplies. The pace is set by the single shift-and-add
//   modular multiplier, which consumes one multiplier bit per cycle.
// Throughput: one item at a time; a new item is taken as soon as the result
//   is in the output register, even while that result waits for out_ready.
// Reset: the modulus returns to 2^31-1 (masked to W bits), the sequencer goes
//   idle and any pending result is dropped.
// Stall: a result that is not taken holds in the output register; a finished
//   computation waits in the done state until that register frees.
`default_nettype none
module modular_exponentiation #(
	parameter int OPERAND_BITS = 31
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [OPERAND_BITS-1:0] base,
	input  wire logic [OPERAND_BITS-1:0] exponent,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [OPERAND_BITS-1:0]      power,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [OPERAND_BITS-1:0] modulus
);

	localparam int W  = OPERAND_BITS;
	localparam int CW = $clog2(W + 1);
	localparam logic [W-1:0]  MOD_RESET = W'(64'h7FFF_FFFF);
	localparam logic [CW-1:0] CNT_LOAD  = CW'(W);
	localparam logic [W-1:0]  ONE       = W'(1);

	modexp_pkg::state_t state_q;

	logic [W-1:0]  mod_q;     // configured modulus
	logic [W-1:0]  x_q;       // running square of the base
	logic [W-1:0]  e_q;       // exponent, shifted right per bit
	logic [W-1:0]  res_q;     // running product
	logic [W-1:0]  acc_q;     // partial remainder / partial product
	logic [W-1:0]  b_q;       // serial operand, MSB first
	logic [CW-1:0] cnt_q;     // bits left in the current pass
	logic          sq_q;      // current multiply is the square
	logic          out_valid_q;
	logic [W-1:0]  power_q;

	logic          mod_small;
	logic [W:0]    mod_ext;
	logic [W:0]    red_sh;
	logic [W-1:0]  red_nxt;
	logic [W:0]    dbl;
	logic [W-1:0]  dbl_red;
	logic [W-1:0]  mul_a;
	logic [W:0]    sum;
	logic [W-1:0]  sum_red;
	logic [W-1:0]  mul_nxt;
	logic          last_bit;
	logic          out_free;
	logic          out_load;

	assign mod_small = (mod_q[W-1:1] == '0);
	assign mod_ext   = {1'b0, mod_q};
	assign last_bit  = (cnt_q == CW'(1));
	assign out_free  = !out_valid_q || out_ready;
	assign out_load  = (state_q == modexp_pkg::ST_DONE) && out_free;

	// Base reduction: shift in one base bit, then one compare and subtract.
	always_comb begin
		red_sh  = {acc_q, b_q[W-1]};
		red_nxt = (red_sh >= mod_ext) ? W'(red_sh - mod_ext) : W'(red_sh);
	end

	// Multiply step: double the accumulator, then add the operand if the bit is set.
	always_comb begin
		mul_a   = sq_q ? x_q : res_q;
		dbl     = {acc_q, 1'b0};
		dbl_red = (dbl >= mod_ext) ? W'(dbl - mod_ext) : W'(dbl);
		sum     = {1'b0, dbl_red} + {1'b0, mul_a};
		sum_red = (sum >= mod_ext) ? W'(sum - mod_ext) : W'(sum);
		mul_nxt = b_q[W-1] ? sum_red : dbl_red;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= modexp_pkg::ST_IDLE;
			mod_q       <= MOD_RESET;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			sq_q        <= 1'b0;
			x_q         <= '0;
			e_q         <= '0;
			res_q       <= '0;
			acc_q       <= '0;
			b_q         <= '0;
		end else begin
			if (cfg_valid) begin
				mod_q <= modulus;
			end
			// Load the output register, else drop the result once transferred.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				modexp_pkg::ST_IDLE: begin
					if (in_valid) begin
						e_q   <= exponent;
						b_q   <= base;
						acc_q <= '0;
						cnt_q <= CNT_LOAD;
						if (mod_small) begin
							// Every residue is zero: skip straight to the answer.
							res_q   <= '0;
							state_q <= modexp_pkg::ST_DONE;
						end else begin
							state_q <= modexp_pkg::ST_RED;
						end
					end
				end
				modexp_pkg::ST_RED: begin
					acc_q <= red_nxt;
					b_q   <= {b_q[W-2:0], 1'b0};
					cnt_q <= cnt_q - CW'(1);
					if (last_bit) begin
						x_q     <= red_nxt;
						res_q   <= ONE;
						state_q <= modexp_pkg::ST_CHK;
					end
				end
				modexp_pkg::ST_CHK: begin
					acc_q <= '0;
					cnt_q <= CNT_LOAD;
					b_q   <= x_q;
					if (e_q == '0) begin
						state_q <= modexp_pkg::ST_DONE;
					end else begin
						sq_q    <= !e_q[0];
						state_q <= modexp_pkg::ST_MUL;
					end
				end
				modexp_pkg::ST_MUL: begin
					if (!last_bit || sq_q) begin
						acc_q <= mul_nxt;
						b_q   <= {b_q[W-2:0], 1'b0};
						cnt_q <= cnt_q - CW'(1);
						if (last_bit) begin
							x_q     <= mul_nxt;
							e_q     <= {1'b0, e_q[W-1:1]};
							state_q <= modexp_pkg::ST_CHK;
						end
					end else begin
						// Product done, follow with the square of the base.
						res_q <= mul_nxt;
						acc_q <= '0;
						b_q   <= x_q;
						cnt_q <= CNT_LOAD;
						sq_q  <= 1'b1;
					end
				end
				modexp_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= modexp_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= modexp_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Output register holds the result until the transfer.
	always_ff @(posedge clk) begin
		if (out_load) begin
			power_q <= res_q;
		end
	end

	assign in_ready  = (state_q == modexp_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign power     = power_q;

	a_res_below_mod: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !mod_small |-> power_q < mod_q)
		else $error("result not reduced below modulus");

	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == modexp_pkg::ST_MUL |-> acc_q < mod_q && x_q < mod_q && res_q < mod_q)
		else $error("multiplier operand out of range");

	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == modexp_pkg::ST_RED || state_q == modexp_pkg::ST_MUL) |-> cnt_q != '0)
		else $error("bit counter ran out during a pass");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q != modexp_pkg::ST_IDLE)
		else $error("accepted item did not start");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == modexp_pkg::ST_DONE && out_free |=> out_valid_q && power_q == $past(res_q))
		else $error("result not moved to output register");

endmodule
`default_nettype wire

@@ sim/modexp_checker.sv @@
`timescale 1ns / 100ps
// Channel monitor for the modular exponentiation block: predicts each power and compares it.
module modexp_checker #(
	parameter int OPERAND_BITS = 31
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic [OPERAND_BITS-1:0] base,
	input  logic [OPERAND_BITS-1:0] exponent,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic [OPERAND_BITS-1:0] power,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [OPERAND_BITS-1:0] modulus,
	output int                      mismatch_count,
	output int                      pending_powers
);

	localparam logic [OPERAND_BITS-1:0] MODULUS_AT_RESET = OPERAND_BITS'(64'h7FFF_FFFF);

	logic [OPERAND_BITS-1:0] modulus_copy = MODULUS_AT_RESET;
	logic [OPERAND_BITS-1:0] expected_powers[$];
	logic [OPERAND_BITS-1:0] oldest_power;
	int                      fail_total = 0;
	int                      waiting_total = 0;

	assign mismatch_count = fail_total;
	assign pending_powers = waiting_total;

	// Right-to-left square-and-multiply; operands stay below 2^31, so 64-bit products are exact.
	function automatic logic [OPERAND_BITS-1:0] predict_power(
		input logic [OPERAND_BITS-1:0] value,
		input logic [OPERAND_BITS-1:0] power_of,
		input logic [OPERAND_BITS-1:0] divisor
	);
		logic [63:0]             acc;
		logic [63:0]             square;
		logic [63:0]             m;
		logic [OPERAND_BITS-1:0] bits_left;
		if (divisor < 2)
			return '0;
		m = 64'(divisor);
		square = 64'(value) % m;
		acc = 64'd1;
		bits_left = power_of;
		while (bits_left != 0) begin
			if (bits_left[0])
				acc = (acc * square) % m;
			square = (square * square) % m;
			bits_left = bits_left >> 1;
		end
		return acc[OPERAND_BITS-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_copy = MODULUS_AT_RESET;
			expected_powers.delete();
			waiting_total = 0;
		end else begin
			// Retire the oldest expectation before queuing a new one.
			if (out_valid && out_ready) begin
				if (expected_powers.size() == 0) begin
					$error("power: no result expected, actual %0d", power);
					fail_total++;
				end else begin
					oldest_power = expected_powers.pop_front();
					if (power !== oldest_power) begin
						$error("power: expected %0d, actual %0d", oldest_power, power);
						fail_total++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				modulus_copy = modulus;
			if (in_valid && in_ready)
				expected_powers.push_back(predict_power(base, exponent, modulus_copy));
			waiting_total = expected_powers.size();
		end
	end

endmodule

@@ sim/tb_modular_exponentiation.sv @@
`timescale 1ns / 100ps
// Top of the modular exponentiation testbench: clock, reset, stimulus and verdict.
module tb_modular_exponentiation;

	localparam int W = 31;
	localparam logic [W-1:0] ALL_ONES = '1;
	// Slowest run is well under 15 ms; allow several times that.
	localparam longint unsigned RUN_LIMIT_NS = 100_000_000;
	localparam int PHASE_COUNT = 8;
	localparam int ITEMS_PER_PHASE = 36;
	// Settle time for the drain, longer than the slowest single item at 31 bits.
	localparam int SETTLE_CYCLES = 2100;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         in_valid = 1'b0;
	logic         in_ready;
	logic [W-1:0] base = '0;
	logic [W-1:0] exponent = '0;
	logic         out_valid;
	logic         out_ready = 1'b0;
	logic [W-1:0] power;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [W-1:0] modulus = '0;

	int           mismatch_count;
	int           pending_powers;

	// Idle percentages of the two sides for the current phase.
	int           sender_idle_pct = 0;
	int           sink_stall_pct = 0;
	// Modulus most recently written, so stimulus can aim at residues.
	logic [W-1:0] current_modulus = ALL_ONES;

	modular_exponentiation #(
		.OPERAND_BITS(W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.base(base),
		.exponent(exponent),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.power(power),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.modulus(modulus)
	);

	modexp_checker #(
		.OPERAND_BITS(W)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.base(base),
		.exponent(exponent),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.power(power),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.modulus(modulus),
		.mismatch_count(mismatch_count),
		.pending_powers(pending_powers)
	);

	always #10 clk = ~clk;

	// Hard stop in case a handshake never completes.
	initial begin
		#(RUN_LIMIT_NS);
		$display("status: fail");
		$finish;
	end

	// Result side: redraw ready at every falling edge from the phase's stall rate.
	initial begin
		forever begin
			@(negedge clk);
			out_ready = ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Offer one item, starting and ending at a falling edge. Valid stays high on
	// return so a back-to-back item only swaps the payload.
	task automatic send_item(input logic [W-1:0] value, input logic [W-1:0] power_of);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		base = value;
		exponent = power_of;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// Drop valid, let every expected power come back, then transfer a new modulus.
	task automatic set_modulus(input logic [W-1:0] value);
		in_valid = 1'b0;
		wait (pending_powers == 0);
		@(negedge clk);
		cfg_valid = 1'b1;
		modulus = value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		current_modulus = value;
	endtask

	// Random item: mostly short exponents to keep the run fast, some full width.
	task automatic send_random_item;
		logic [W-1:0] value;
		logic [W-1:0] power_of;
		int           len;
		case ($urandom_range(3))
			0, 1: value = W'($urandom);
			2: value = (current_modulus >= 2) ? W'($urandom % current_modulus) : W'($urandom);
			default: begin
				case ($urandom_range(3))
					0: value = '0;
					1: value = W'(1);
					2: value = current_modulus - W'(1);
					default: value = ALL_ONES;
				endcase
			end
		endcase
		len = ($urandom_range(99) < 75) ? $urandom_range(0, 12) : $urandom_range(13, W);
		power_of = W'($urandom) & ((W'(1) << len) - W'(1));
		if (len > 0)
			power_of[len-1] = 1'b1;
		send_item(value, power_of);
	endtask

	initial begin
		int           phase;
		int           n;
		logic [W-1:0] next_modulus;

		// Hold reset, then release it at a falling edge, away from the rising edge.
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part under the reset modulus 2^31-1.
		send_item('0, '0);                      // zero exponent gives 1
		send_item(ALL_ONES, '0);                // unreduced base, zero exponent
		send_item('0, W'(5));
		send_item(ALL_ONES, ALL_ONES);          // base equal to the modulus
		send_item(ALL_ONES - W'(1), ALL_ONES);  // largest possible power
		send_item(ALL_ONES - W'(1), ALL_ONES - W'(1));
		send_item(W'(2), W'(30));
		send_item(W'(2), W'(31));
		send_item(W'(3), ALL_ONES - W'(1));
		send_item(W'(1), ALL_ONES);
		send_item(W'(12345), W'(1));
		send_item(W'(31'h5555_5555), W'(31'h2AAA_AAAA));

		// Small modulus with bases far above it and one just below it.
		set_modulus(W'(13));
		send_item(ALL_ONES, W'(2));
		send_item(W'(31'h4000_0000), ALL_ONES);
		send_item(W'(12), W'(1));

		// Smallest meaningful modulus.
		set_modulus(W'(2));
		send_item('0, '0);
		send_item(W'(3), ALL_ONES);
		send_item(W'(4), W'(7));

		// Modulus of one: every power is 0, zero exponent included.
		set_modulus(W'(1));
		send_item(W'(5), '0);
		send_item(ALL_ONES, ALL_ONES);

		// Modulus of zero: no meaning, power is 0.
		set_modulus('0);
		send_item(W'(7), W'(3));
		send_item('0, '0);

		// Random phases: rotate the modulus and the idle pattern.
		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase)
				0: next_modulus = ALL_ONES;
				1: next_modulus = W'(2);
				2: next_modulus = W'($urandom) | W'(31'h4000_0000);
				3: next_modulus = W'($urandom_range(3, 4096));
				4: next_modulus = W'(1);
				5: next_modulus = W'($urandom) | W'(1);
				6: next_modulus = W'(65537);
				default: next_modulus = W'($urandom);
			endcase
			set_modulus(next_modulus);
			case (phase % 4)
				0: begin
					sender_idle_pct = 0;
					sink_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 81;
					sink_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					sink_stall_pct = 81;
				end
				default: begin
					sender_idle_pct = 8;
					sink_stall_pct = 8;
				end
			endcase
			for (n = 0; n < ITEMS_PER_PHASE; n++)
				send_random_item();
		end

		// Drain: wait for the last power, then let the block settle.
		in_valid = 1'b0;
		wait (pending_powers == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_powers == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
